/* hw/rtl/mmm_pkg.sv */
// shared types and constants for the multichannel min/max/mean core
// no dependencies; every file but mmm_fifo refers to it by scoped names
package mmm_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned NumCh   = 5;
  localparam int unsigned ChW     = 3;

  localparam logic [ChW-1:0] LastCh = ChW'(NumCh - 1);

  // one record, channel 0 (air temp) in the lowest slice
  typedef logic [NumCh-1:0][SampleW-1:0] rec_t;

  // how the back end treats one queued record
  typedef struct packed {
    logic first;    // first record of the run, seeds min/max/sum
    logic take;     // accumulate this record
    logic last;     // run ends with this record
    logic dropped;  // some record of the run was dropped so far
  } ctl_t;

endpackage

/* hw/rtl/mmm_front.sv */
// front end: accepts records, counts the run and tags each record
// depends on mmm_pkg
module mmm_front #(
  parameter int unsigned MaxSamples = 4096,
  parameter int unsigned CntW       = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  mmm_pkg::rec_t       s_rec_i,
  input  logic                s_last_i,
  input  logic                q_full_i,
  output logic                push_o,
  output mmm_pkg::ctl_t       ctl_o,
  output logic [CntW-1:0]     cnt_o,
  output mmm_pkg::rec_t       rec_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxSamples);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            drop_q, drop_d;
  logic            take;

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;
  assign take      = cnt_q < MaxCnt;

  assign ctl_o.first   = (cnt_q == '0);
  assign ctl_o.take    = take;
  assign ctl_o.last    = s_last_i;
  assign ctl_o.dropped = drop_q || !take;
  assign cnt_o         = take ? cnt_q + CntW'(1) : cnt_q;
  assign rec_o         = s_rec_i;

  always_comb begin
    cnt_d  = cnt_q;
    drop_d = drop_q;
    if (push_o) begin
      if (s_last_i) begin
        cnt_d  = '0;
        drop_d = 1'b0;
      end else begin
        cnt_d  = cnt_o;
        drop_d = ctl_o.dropped;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

endmodule

/* hw/rtl/mmm_fifo.sv */
// two-entry queue between the front end and the back end
// no package dependency
module mmm_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       used_q;

  assign full_o  = used_q[1];
  assign empty_o = (used_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      used_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   used_q <= used_q + 2'd1;
        2'b01:   used_q <= used_q - 2'd1;
        default: used_q <= used_q;
      endcase
    end
  end

endmodule

/* hw/rtl/mmm_div.sv */
// bit-serial restoring divider: signed sum over unsigned count, toward zero
// depends on mmm_pkg
module mmm_div #(
  parameter int unsigned SumW = 29,
  parameter int unsigned CntW = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        neg_i,
  input  logic [SumW-1:0]             dividend_i,
  input  logic [CntW-1:0]             divisor_i,
  output logic                        done_o,
  output logic [mmm_pkg::SampleW-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(SumW);
  localparam logic [StepW-1:0] LastStep = StepW'(SumW - 1);

  logic              busy_q;
  logic              neg_q;
  logic [StepW-1:0]  step_q;
  logic [CntW-1:0]   rem_q, divisor_q;
  logic [SumW-1:0]   quo_q, quo_signed;
  logic [CntW:0]     trial, diff;
  logic              ge;

  // shift the next dividend bit in, quotient bits fill from the bottom
  assign trial = {rem_q, quo_q[SumW-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = trial >= {1'b0, divisor_q};

  assign done_o     = busy_q && (step_q == LastStep);
  assign quo_signed = neg_q ? (~quo_q + SumW'(1)) : quo_q;
  assign quot_o     = quo_signed[mmm_pkg::SampleW-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
      neg_q     <= neg_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[CntW-1:0] : trial[CntW-1:0];
      quo_q <= {quo_q[SumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      busy_q <= !done_o;
      step_q <= step_q + StepW'(1);
    end
  end

endmodule

/* hw/rtl/mmm_back.sv */
// back end: per-channel min/max/sum, run-end divide and result register
// depends on mmm_pkg and mmm_div
module mmm_back #(
  parameter int unsigned CntW = 13,
  parameter int unsigned SumW = 29
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  output logic                        pop_o,
  input  mmm_pkg::ctl_t               ctl_i,
  input  logic [CntW-1:0]             cnt_i,
  input  mmm_pkg::rec_t               rec_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [mmm_pkg::ChW-1:0]     m_ch_o,
  output logic [mmm_pkg::SampleW-1:0] m_min_o,
  output logic [mmm_pkg::SampleW-1:0] m_max_o,
  output logic [mmm_pkg::SampleW-1:0] m_mean_o,
  output logic                        m_ovf_o,
  output logic                        m_last_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic signed [SumW-1:0]             sum_q [mmm_pkg::NumCh];
  logic signed [mmm_pkg::SampleW-1:0] min_q [mmm_pkg::NumCh];
  logic signed [mmm_pkg::SampleW-1:0] max_q [mmm_pkg::NumCh];

  logic [mmm_pkg::ChW-1:0] ch_q, ch_d;
  logic [CntW-1:0]         cnt_q;
  logic                    ovf_q;
  logic                    out_valid_q;

  logic                        accum;
  logic                        emit;
  logic                        div_start, div_done;
  logic signed [SumW-1:0]      sum_sel;
  logic [SumW-1:0]             sum_mag;
  logic [mmm_pkg::SampleW-1:0] quot;

  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign accum     = pop_o && ctl_i.take;
  assign emit      = (state_q == ST_EMIT) && (!out_valid_q || m_ready_i);
  assign div_start = (state_q == ST_START);

  assign sum_sel = sum_q[ch_q];
  assign sum_mag = sum_sel[SumW-1] ? SumW'(-sum_sel) : SumW'(sum_sel);

  mmm_div #(
    .SumW (SumW),
    .CntW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .neg_i      (sum_sel[SumW-1]),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < mmm_pkg::NumCh; c++) begin
      if (accum) begin
        if (ctl_i.first) begin
          sum_q[c] <= SumW'($signed(rec_i[c]));
          min_q[c] <= $signed(rec_i[c]);
          max_q[c] <= $signed(rec_i[c]);
        end else begin
          sum_q[c] <= sum_q[c] + SumW'($signed(rec_i[c]));
          if ($signed(rec_i[c]) < min_q[c]) min_q[c] <= $signed(rec_i[c]);
          if ($signed(rec_i[c]) > max_q[c]) max_q[c] <= $signed(rec_i[c]);
        end
      end
    end
  end

  // run totals latched from the last-marked record
  always_ff @(posedge clk_i) begin
    if (pop_o && ctl_i.last) begin
      cnt_q <= cnt_i;
      ovf_q <= ctl_i.dropped;
    end
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o && ctl_i.last) begin
          state_d = ST_START;
          ch_d    = '0;
        end
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          if (ch_q == mmm_pkg::LastCh) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_START;
            ch_d    = ch_q + mmm_pkg::ChW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_ch_o   <= ch_q;
      m_min_o  <= min_q[ch_q];
      m_max_o  <= max_q[ch_q];
      m_mean_o <= quot;
      m_ovf_o  <= ovf_q;
      m_last_o <= (ch_q == mmm_pkg::LastCh);
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

/* hw/rtl/multichannel_min_max_mean_core.sv */
// top level of the multichannel running min/max/mean core
// depends on mmm_pkg, mmm_front, mmm_fifo and mmm_back
//
// input stream: one record of five signed 16-bit samples per beat, tlast
// marks the final record of a run. records are taken one per cycle while
// the two-entry queue has room; while idle, the back end folds one record
// per cycle into per-channel min, max and sum. at most MaxSamples records
// of a run are folded in, later ones only raise the overflow flag.
// after a last-marked record the back end emits five results in channel
// order, tlast on the light channel. each result runs the shared
// bit-serial divider, one quotient bit a cycle; records keep queuing
// meanwhile until the queue fills. a stalled receiver holds the result
// register, which stops the back end and, once the queue is full, the
// input side. reset clears the run count, queue and result valid flag;
// no clearing pass is needed, the first record of a run seeds the
// accumulators
module multichannel_min_max_mean_core #(
  parameter int unsigned MaxSamples = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // air_temp, soil_temp, air_hum, soil_hum, light_level (16 bits each)
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // minimum, maximum, mean (16 bits each)
  output logic [47:0] m_axis_tdata,
  // channel [2:0], overflow [3]
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned CntW   = $clog2(MaxSamples + 1);
  localparam int unsigned SumW   = mmm_pkg::SampleW + CntW;
  localparam int unsigned EntryW = CntW + $bits(mmm_pkg::ctl_t) + $bits(mmm_pkg::rec_t);

  logic                        push, pop, q_full, q_empty;
  mmm_pkg::ctl_t               f_ctl, b_ctl;
  logic [CntW-1:0]             f_cnt, b_cnt;
  mmm_pkg::rec_t               f_rec, b_rec;
  logic [EntryW-1:0]           q_wdata, q_rdata;
  logic [mmm_pkg::ChW-1:0]     out_ch;
  logic [mmm_pkg::SampleW-1:0] out_min, out_max, out_mean;
  logic                        out_ovf;

  mmm_front #(
    .MaxSamples (MaxSamples),
    .CntW       (CntW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_rec_i   (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .q_full_i  (q_full),
    .push_o    (push),
    .ctl_o     (f_ctl),
    .cnt_o     (f_cnt),
    .rec_o     (f_rec)
  );

  assign q_wdata = {f_cnt, f_ctl, f_rec};

  mmm_fifo #(
    .Width (EntryW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  assign {b_cnt, b_ctl, b_rec} = q_rdata;

  mmm_back #(
    .CntW (CntW),
    .SumW (SumW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .pop_o     (pop),
    .ctl_i     (b_ctl),
    .cnt_i     (b_cnt),
    .rec_i     (b_rec),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_ch_o    (out_ch),
    .m_min_o   (out_min),
    .m_max_o   (out_max),
    .m_mean_o  (out_mean),
    .m_ovf_o   (out_ovf),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_mean, out_max, out_min};
  assign m_axis_tuser = {out_ovf, out_ch};

endmodule

/* hw/rtl/mmm_checker.sv */
// port-level checks for the multichannel min/max/mean core, bound to the top
// depends on mmm_pkg; sees the core only through its ports
module mmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // tlast only on the light channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:0] == mmm_pkg::LastCh)))
    else $error("tlast not on the light channel");

  // the channel field stays within the five channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[2:0] <= mmm_pkg::LastCh))
    else $error("channel out of range");

  // the mean lies between minimum and maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= $signed(m_axis_tdata[47:32]))
      && ($signed(m_axis_tdata[47:32]) <= $signed(m_axis_tdata[31:16])))
    else $error("mean outside min/max");

endmodule

bind multichannel_min_max_mean_core mmm_checker u_mmm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/tb_multichannel_min_max_mean_core.sv */
// self-checking testbench for multichannel_min_max_mean_core
// depends on mmm_pkg and the core; records stream in, per-channel min, max and mean
// results are compared against an in-bench model or the directed rows' expected values
module tb_multichannel_min_max_mean_core;
  timeunit 1ns;
  timeprecision 1ps;

  // default capacity of the core
  localparam int unsigned MAX_SAMPLES  = 4096;
  localparam int unsigned RAND_RECORDS = 170;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef enum logic [mmm_pkg::ChW-1:0] {
    CH_AIR_TEMP, CH_SOIL_TEMP, CH_AIR_HUM, CH_SOIL_HUM, CH_LIGHT
  } chan_e;

  typedef struct {
    chan_e                       ch;
    logic [mmm_pkg::SampleW-1:0] lo;
    logic [mmm_pkg::SampleW-1:0] hi;
    logic [mmm_pkg::SampleW-1:0] avg;
    bit                          ovf;
    bit                          fin;
  } stat_t;

  // one directed record; typed rows carry their expected statistics
  typedef struct {
    mmm_pkg::rec_t smp;
    bit            last;
    bit            typed;
    mmm_pkg::rec_t lo;
    mmm_pkg::rec_t hi;
    mmm_pkg::rec_t avg;
    bit            ovf;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  multichannel_min_max_mean_core #(
    .MaxSamples(MAX_SAMPLES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // running statistics of the current run
  longint                             run_sum [mmm_pkg::NumCh];
  logic signed [mmm_pkg::SampleW-1:0] run_min [mmm_pkg::NumCh];
  logic signed [mmm_pkg::SampleW-1:0] run_max [mmm_pkg::NumCh];
  int unsigned                        run_taken;
  bit                                 run_dropped;

  stat_t       stats_due[$];
  plan_row_t   plan[$];
  int unsigned errors;
  int unsigned stats_seen;
  int unsigned cycles;

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void clear_run();
    for (int c = 0; c < mmm_pkg::NumCh; c++) begin
      run_sum[c] = 0;
      run_min[c] = '0;
      run_max[c] = '0;
    end
    run_taken   = 0;
    run_dropped = 1'b0;
  endfunction

  // fold one record into the run; a last-marked record closes the run
  function automatic void fold_record(mmm_pkg::rec_t smp, bit last, bit push);
    logic signed [mmm_pkg::SampleW-1:0] v;
    longint                             q;
    stat_t                              s;
    if (run_taken < MAX_SAMPLES) begin
      for (int c = 0; c < mmm_pkg::NumCh; c++) begin
        v = smp[c];
        if (run_taken == 0) begin
          run_min[c] = v;
          run_max[c] = v;
        end else begin
          if (v < run_min[c]) run_min[c] = v;
          if (v > run_max[c]) run_max[c] = v;
        end
        run_sum[c] += v;
      end
      run_taken++;
    end else begin
      run_dropped = 1'b1;
    end
    if (!last) return;
    if (push) begin
      for (int c = 0; c < mmm_pkg::NumCh; c++) begin
        // longint division truncates toward zero
        q     = run_sum[c] / longint'(run_taken);
        s.ch  = chan_e'(c);
        s.lo  = run_min[c];
        s.hi  = run_max[c];
        s.avg = q[mmm_pkg::SampleW-1:0];
        s.ovf = run_dropped;
        s.fin = (s.ch == CH_LIGHT);
        stats_due.push_back(s);
      end
    end
    clear_run();
  endfunction

  function automatic void push_typed(plan_row_t r);
    stat_t s;
    for (int c = 0; c < mmm_pkg::NumCh; c++) begin
      s.ch  = chan_e'(c);
      s.lo  = r.lo[c];
      s.hi  = r.hi[c];
      s.avg = r.avg[c];
      s.ovf = r.ovf;
      s.fin = (s.ch == CH_LIGHT);
      stats_due.push_back(s);
    end
  endfunction

  function automatic void add_row(mmm_pkg::rec_t smp, bit last, bit typed = 1'b0,
                                  mmm_pkg::rec_t lo = '0, mmm_pkg::rec_t hi = '0,
                                  mmm_pkg::rec_t avg = '0, bit ovf = 1'b0);
    plan_row_t r;
    r.smp   = smp;
    r.last  = last;
    r.typed = typed;
    r.lo    = lo;
    r.hi    = hi;
    r.avg   = avg;
    r.ovf   = ovf;
    plan.push_back(r);
  endfunction

  function automatic void build_plan();
    mmm_pkg::rec_t mixed;
    mixed = {16'h5555, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF};
    // single-record runs: min, max and mean all equal the sample
    add_row('0, 1'b1, 1'b1, '0, '0, '0);
    add_row({5{16'h7FFF}}, 1'b1, 1'b1, {5{16'h7FFF}}, {5{16'h7FFF}}, {5{16'h7FFF}});
    add_row({5{16'h8000}}, 1'b1, 1'b1, {5{16'h8000}}, {5{16'h8000}}, {5{16'h8000}});
    add_row(mixed, 1'b1, 1'b1, mixed, mixed, mixed);
    // both extremes in one run, mean -1/2 truncates to zero
    add_row({5{16'h7FFF}}, 1'b0);
    add_row({5{16'h8000}}, 1'b1, 1'b1, {5{16'h8000}}, {5{16'h7FFF}}, '0);
    // negative mean that must not round toward minus infinity
    add_row({5{16'hFFFF}}, 1'b0);
    add_row({16'h0003, 16'hFFFE, 16'h0000, 16'h0002, 16'hFFFF}, 1'b0);
    add_row({16'h0000, 16'h0001, 16'h0000, 16'hFFF9, 16'h0000}, 1'b1);
  endfunction

  function automatic logic [mmm_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // present one record and hold it until the request is taken
  task automatic send_record(mmm_pkg::rec_t smp, bit last, bit steady);
    while (!steady && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic cmp_field(string name, int unsigned idx, logic [15:0] got,
                           logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got %h, want %h", idx, name, got, want));
  endtask

  task automatic check_stat();
    stat_t want;
    if (stats_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected result, channel %0d", m_axis_tuser[2:0]));
      return;
    end
    want = stats_due.pop_front();
    cmp_field("channel",  stats_seen, 16'(m_axis_tuser[2:0]), 16'(want.ch));
    cmp_field("minimum",  stats_seen, m_axis_tdata[15:0],     want.lo);
    cmp_field("maximum",  stats_seen, m_axis_tdata[31:16],    want.hi);
    cmp_field("mean",     stats_seen, m_axis_tdata[47:32],    want.avg);
    cmp_field("overflow", stats_seen, 16'(m_axis_tuser[3]),   16'(want.ovf));
    cmp_field("tlast",    stats_seen, 16'(m_axis_tlast),      16'(want.fin));
  endtask

  // result side: random back-pressure, none while a stretch of results streams by
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_stat();
        stats_seen++;
      end
      m_axis_tready <= (stats_seen >= 60 && stats_seen < 110) || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    mmm_pkg::rec_t smp;
    int unsigned   run_len;
    int unsigned   sent;
    bit            last;
    errors        = 0;
    stats_seen    = 0;
    cycles        = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    clear_run();
    build_plan();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_record(plan[i].smp, plan[i].last, 1'b0);
      fold_record(plan[i].smp, plan[i].last, !plan[i].typed);
      if (plan[i].typed) push_typed(plan[i]);
    end

    // random runs, now and then a longer one
    sent = 0;
    while (sent < RAND_RECORDS) begin
      if ($urandom_range(7) == 0)
        run_len = $urandom_range(24, 12);
      else
        run_len = $urandom_range(6, 1);
      for (int k = 0; k < run_len; k++) begin
        for (int c = 0; c < mmm_pkg::NumCh; c++) smp[c] = pick_sample();
        last = (k == run_len - 1);
        send_record(smp, last, sent >= 60 && sent < 120);
        fold_record(smp, last, 1'b1);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
